### rtl/core/epd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_pkg - shared types and constants of the escaped packet deframer
// Register indexes, reset values, sizes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package epd_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd3;

	// reset values
	localparam logic [LEN_W-1:0]  RST_MAX_LENGTH  = LEN_W'(MAX_PAYLOAD);
	localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'hff;
	localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'hfe;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'hfd;

	// controller -> datapath
	typedef struct packed {
		logic open;      // clear length, counters, checksum and read index
		logic load_len;  // latch the length byte
		logic take_byte; // store a payload byte and add it to the sum
		logic out_load;  // move the read word into the output register and step the read index
	} epd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic is_end;
		logic is_esc;
		logic len_ok;
		logic len_zero;
		logic sum_ok;
		logic pay_done;
		logic rd_last;
		logic out_free;
	} epd_status_t;

endpackage
`default_nettype wire

### rtl/core/escaped_packet_deframer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_packet_deframer_unit - byte-stuffed frame receiver
// Recovers start/length/payload/checksum/end frames from a received byte
// stream and delivers the payload of each good frame byte by byte.
// ----------------------------------------------------------------------------
// Usage: received bytes are taken at one per cycle while a frame is being
// parsed or hunted for. When the end code of a good frame is taken, input
// stalls while the payload drains: each result takes a registered buffer
// read (S_RD) and then a load of the result register (S_LOAD), which waits
// while the result side stalls; an empty frame still yields one result, a
// zero byte with last set. The result register decouples the two sides, so
// the next byte is taken while the final result waits for its
// transfer. The 64-byte payload buffer needs no clearing after reset: only
// entries written in the current frame are ever read. Config registers
// (max_length, start_code, end_code, escape_code) are written through
// cfg_we/cfg_index/cfg_data and should only change while no frame is draining.
// ----------------------------------------------------------------------------
module escaped_packet_deframer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config write port
	input  wire logic                          cfg_we,
	input  wire logic [epd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [epd_pkg::BYTE_W-1:0]    cfg_data,
	// received bytes
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [epd_pkg::BYTE_W-1:0]    rx_byte,
	// payload results
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [epd_pkg::BYTE_W-1:0]         payload_byte,
	output logic [epd_pkg::IDX_W-1:0]          byte_index,
	output logic [epd_pkg::LEN_W-1:0]          frame_length,
	output logic                               last
);
	import epd_pkg::*;

	epd_cmd_t    cmd;
	epd_status_t st;

	// phase tracking, escape handling and drain sequencing
	epd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// code compares, counters, checksum, payload buffer, result register
	epd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length),
		.last         (last)
	);

endmodule
`default_nettype wire

### rtl/core/epd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_ctrl - framing state machine
// Tracks the frame phase and pending escape and sequences the payload drain.
// ----------------------------------------------------------------------------
module epd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire epd_pkg::epd_status_t st,
	output epd_pkg::epd_cmd_t         cmd
);
	import epd_pkg::*;

	typedef enum logic [6:0] {
		S_HUNT    = 7'b0000001,
		S_LENGTH  = 7'b0000010,
		S_PAYLOAD = 7'b0000100,
		S_CHECK   = 7'b0001000,
		S_END     = 7'b0010000,
		S_RD      = 7'b0100000,
		S_LOAD    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   escaped_q, escaped_d;
	logic   fire;
	logic   field;
	logic   data;

	assign in_ready = (state_q != S_RD) && (state_q != S_LOAD);
	assign fire     = in_valid && in_ready;
	assign field    = (state_q == S_LENGTH) || (state_q == S_PAYLOAD) || (state_q == S_CHECK);
	// escaped byte is literal; otherwise any code byte is not data
	assign data     = escaped_q || (!st.is_start && !st.is_end && !st.is_esc);

	always_comb begin
		state_d   = state_q;
		escaped_d = escaped_q;
		cmd       = '0;
		unique case (state_q) inside
			S_HUNT: begin
				if (fire && st.is_start) begin
					cmd.open = 1'b1;
					state_d  = S_LENGTH;
				end
			end
			S_LENGTH, S_PAYLOAD, S_CHECK: begin
				if (fire) begin
					if (escaped_q) begin
						escaped_d = 1'b0;
					end else if (st.is_start) begin
						cmd.open = 1'b1;
						state_d  = S_LENGTH;
					end else if (st.is_end) begin
						state_d = S_HUNT;
					end else if (st.is_esc) begin
						escaped_d = 1'b1;
					end
					if (data) begin
						if (state_q == S_LENGTH) begin
							if (!st.len_ok) begin
								state_d = S_HUNT;
							end else begin
								cmd.load_len = 1'b1;
								state_d      = st.len_zero ? S_CHECK : S_PAYLOAD;
							end
						end else if (state_q == S_PAYLOAD) begin
							cmd.take_byte = 1'b1;
							if (st.pay_done) begin
								state_d = S_CHECK;
							end
						end else begin
							state_d = st.sum_ok ? S_END : S_HUNT;
						end
					end
				end
			end
			S_END: begin
				if (fire) begin
					if (st.is_end) begin
						state_d = S_RD;
					end else if (st.is_start) begin
						cmd.open = 1'b1;
						state_d  = S_LENGTH;
					end else begin
						state_d = S_HUNT;
					end
				end
			end
			S_RD: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = st.rd_last ? S_HUNT : S_RD;
				end
			end
			default: begin
				state_d   = S_HUNT;
				escaped_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_HUNT;
			escaped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			escaped_q <= escaped_d;
		end
	end

	// a pending escape only lives inside a field
	a_esc_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		escaped_q |-> field)
		else $error("escape pending outside a frame field");

	// the drain holds off input until the last result is loaded
	a_drain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && !cmd.out_load) |=> !in_ready)
		else $error("input taken during payload drain");

endmodule
`default_nettype wire

### rtl/core/epd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epd_dp - deframer datapath
// Code registers and compares, length/count/checksum, payload buffer, result
// register.
// ----------------------------------------------------------------------------
module epd_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [epd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [epd_pkg::BYTE_W-1:0]       cfg_data,
	input  wire logic [epd_pkg::BYTE_W-1:0]       rx_byte,
	input  wire epd_pkg::epd_cmd_t                cmd,
	output epd_pkg::epd_status_t                  st,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [epd_pkg::BYTE_W-1:0]            payload_byte,
	output logic [epd_pkg::IDX_W-1:0]             byte_index,
	output logic [epd_pkg::LEN_W-1:0]             frame_length,
	output logic                                  last
);
	import epd_pkg::*;

	logic [LEN_W-1:0]  max_length_q;
	logic [BYTE_W-1:0] start_code_q;
	logic [BYTE_W-1:0] end_code_q;
	logic [BYTE_W-1:0] escape_code_q;

	logic [LEN_W-1:0]  frame_len_q;
	logic [LEN_W-1:0]  bytes_taken_q;
	logic [BYTE_W-1:0] sum_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	logic [LEN_W-1:0]  rd_next;
	logic              len_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q  <= RST_MAX_LENGTH;
			start_code_q  <= RST_START_CODE;
			end_code_q    <= RST_END_CODE;
			escape_code_q <= RST_ESCAPE_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LENGTH:  max_length_q  <= cfg_data[LEN_W-1:0];
				REG_START_CODE:  start_code_q  <= cfg_data;
				REG_END_CODE:    end_code_q    <= cfg_data;
				REG_ESCAPE_CODE: escape_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rd_next   = LEN_W'(rd_idx_q) + LEN_W'(1);
	assign len_empty = (frame_len_q == '0);

	always_comb begin
		st.is_start = (rx_byte == start_code_q);
		st.is_end   = (rx_byte == end_code_q);
		st.is_esc   = (rx_byte == escape_code_q);
		st.len_ok   = (rx_byte <= {1'b0, max_length_q}) && (rx_byte <= BYTE_W'(MAX_PAYLOAD));
		st.len_zero = (rx_byte == '0);
		st.sum_ok   = (rx_byte == sum_q);
		st.pay_done = ((bytes_taken_q + LEN_W'(1)) >= frame_len_q);
		st.rd_last  = len_empty || (rd_next >= frame_len_q);
		st.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q   <= '0;
			bytes_taken_q <= '0;
			sum_q         <= '0;
			rd_idx_q      <= '0;
		end else begin
			if (cmd.open) begin
				frame_len_q   <= '0;
				bytes_taken_q <= '0;
				sum_q         <= '0;
				rd_idx_q      <= '0;
			end
			if (cmd.load_len) begin
				frame_len_q <= rx_byte[LEN_W-1:0];
			end
			if (cmd.take_byte) begin
				bytes_taken_q <= bytes_taken_q + LEN_W'(1);
				sum_q         <= sum_q + rx_byte;
			end
			if (cmd.out_load) begin
				rd_idx_q <= rd_next[IDX_W-1:0];
			end
		end
	end

	// payload buffer, registered read
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			mem[bytes_taken_q[IDX_W-1:0]] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= len_empty ? '0 : rd_data_q;
			out_idx_q  <= rd_idx_q;
			out_len_q  <= frame_len_q;
			out_last_q <= st.rd_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign byte_index   = out_idx_q;
	assign frame_length = out_len_q;
	assign last         = out_last_q;

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_byte |-> (bytes_taken_q < frame_len_q))
		else $error("payload write beyond frame length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

	a_read_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !len_empty) |-> (LEN_W'(rd_idx_q) < frame_len_q))
		else $error("payload read beyond frame length");

endmodule
`default_nettype wire
